### hdl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// shared constants for the grid maze router: grid geometry, item and cell codes
// ----------------------------------------------------------------------------
`default_nettype none

package gmb_pkg;

  localparam int unsigned RowBits   = 6;
  localparam int unsigned ColBits   = 6;
  localparam int unsigned CellBits  = RowBits + ColBits;
  localparam int unsigned MaxRows   = 1 << RowBits;
  localparam int unsigned MaxCols   = 1 << ColBits;
  localparam int unsigned CountBits = 7;
  localparam int unsigned LenBits   = 12;

  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncSolve = 2'd1;
  localparam logic [1:0] FuncFetch = 2'd2;

  localparam logic [1:0] KindOpen   = 2'd0;
  localparam logic [1:0] KindWall   = 2'd1;
  localparam logic [1:0] KindStart  = 2'd2;
  localparam logic [1:0] KindTarget = 2'd3;

  localparam logic [1:0] MoveUp    = 2'd0;
  localparam logic [1:0] MoveDown  = 2'd1;
  localparam logic [1:0] MoveLeft  = 2'd2;
  localparam logic [1:0] MoveRight = 2'd3;

  localparam logic RegRowCount = 1'b0;
  localparam logic RegColCount = 1'b1;

  localparam logic [CountBits-1:0] RowLimit = CountBits'(MaxRows);
  localparam logic [CountBits-1:0] ColLimit = CountBits'(MaxCols);

endpackage

`default_nettype wire

### hdl/grid_maze_bfs_router.sv
// ----------------------------------------------------------------------------
// grid_maze_bfs_router
// lee router: cell loads, breadth-first solve with trace-back, move fetches
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       sink       in_valid_i / in_stall_o func, row, col, cell_kind
// out      source     out_valid_o/ out_stall_i found, path_length, move,
//                                              valid_move, last_move
// cfg      sink       cfg_we_i                cfg_index_i, cfg_wdata_i
//
// a load writes the cell memory directly; a fetch reads the path memory, or
// skips the read past the end of the path, before its result is offered.
// a solve clears the whole visit map, then expands cells by probing neighbors
// and traces back; its probes share the single visit/distance read port.
// one item is in work at a time; a finished result waits in the output
// register and holds there while out_stall_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_bfs_router (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         func_i,
  input  wire logic [gmb_pkg::RowBits-1:0]        row_i,
  input  wire logic [gmb_pkg::ColBits-1:0]        col_i,
  input  wire logic [1:0]                         cell_kind_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    found_o,
  output logic      [gmb_pkg::LenBits-1:0]        path_length_o,
  output logic      [1:0]                         move_o,
  output logic                                    valid_move_o,
  output logic                                    last_move_o,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [gmb_pkg::CountBits-1:0]      cfg_wdata_i
);

  localparam int unsigned CB = gmb_pkg::CellBits;
  localparam int unsigned LB = gmb_pkg::LenBits;
  localparam int unsigned NB = gmb_pkg::CountBits;
  localparam int unsigned RB = gmb_pkg::RowBits;
  localparam int unsigned KB = gmb_pkg::ColBits;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_POP    = 4'd3;
  localparam logic [3:0] S_CUR    = 4'd4;
  localparam logic [3:0] S_DIST   = 4'd5;
  localparam logic [3:0] S_PROBE  = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_TGT    = 4'd8;
  localparam logic [3:0] S_TGT2   = 4'd9;
  localparam logic [3:0] S_TPROBE = 4'd10;
  localparam logic [3:0] S_TCHK   = 4'd11;
  localparam logic [3:0] S_FETCH  = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [NB-1:0] row_count_q, col_count_q;
  logic [CB-1:0] start_q, start_d, target_q, target_d;
  logic [LB-1:0] ptr_q, ptr_d, total_q, total_d;
  logic [CB:0]   head_q, head_d, tail_q, tail_d;
  logic [CB-1:0] cur_q, cur_d, nb_q, nb_d, clr_q, clr_d;
  logic [LB-1:0] dcur_q, dcur_d, dist_q, dist_d;
  logic [1:0]    k_q, k_d, j_q, j_d;
  logic [RB-1:0] tr_q, tr_d;
  logic [KB-1:0] tc_q, tc_d;
  logic          res_found_q, res_found_d, res_vmove_q, res_vmove_d;
  logic          res_last_q, res_last_d;
  logic [LB-1:0] res_len_q, res_len_d;
  logic [1:0]    res_move_q, res_move_d;
  logic          out_valid_q, out_valid_d;
  logic          found_q, vmove_q, last_q;
  logic [LB-1:0] len_q;
  logic [1:0]    move_q;
  logic          out_load;

  // memory ports
  logic          cell_we, vd_we, q_we, path_we;
  logic [CB-1:0] cell_waddr, cell_raddr, vd_waddr, vd_raddr, q_waddr, q_raddr;
  logic [CB-1:0] path_waddr, path_raddr;
  logic [1:0]    cell_wdata, cell_rdata, path_wdata, path_rdata;
  logic [LB:0]   vd_wdata, vd_rdata;
  logic [CB-1:0] q_wdata, q_rdata;

  logic [NB-1:0] nr_eff, nc_eff;
  logic          in_acc;
  logic [RB-1:0] cr, trr;
  logic [KB-1:0] cc, tcc;
  logic [LB-1:0] want;

  gmb_ram #(.Width(2), .AddrBits(CB)) u_cell_ram (
    .clk_i, .we_i(cell_we), .waddr_i(cell_waddr), .wdata_i(cell_wdata),
    .raddr_i(cell_raddr), .rdata_o(cell_rdata));

  // visited flag on top of the distance
  gmb_ram #(.Width(LB + 1), .AddrBits(CB)) u_vd_ram (
    .clk_i, .we_i(vd_we), .waddr_i(vd_waddr), .wdata_i(vd_wdata),
    .raddr_i(vd_raddr), .rdata_o(vd_rdata));

  gmb_ram #(.Width(CB), .AddrBits(CB)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata));

  gmb_ram #(.Width(2), .AddrBits(CB)) u_path_ram (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata));

  always_comb begin
    if (row_count_q == '0) nr_eff = NB'(1);
    else if (row_count_q > gmb_pkg::RowLimit) nr_eff = gmb_pkg::RowLimit;
    else nr_eff = row_count_q;
    if (col_count_q == '0) nc_eff = NB'(1);
    else if (col_count_q > gmb_pkg::ColLimit) nc_eff = gmb_pkg::ColLimit;
    else nc_eff = col_count_q;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = !out_valid_q || !out_stall_i;

  assign cr   = cur_q[CB-1:KB];
  assign cc   = cur_q[KB-1:0];
  assign trr  = tr_q;
  assign tcc  = tc_q;
  assign want = dist_q - LB'(1);

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    target_d    = target_q;
    ptr_d       = ptr_q;
    total_d     = total_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    nb_d        = nb_q;
    clr_d       = clr_q;
    dcur_d      = dcur_q;
    dist_d      = dist_q;
    k_d         = k_q;
    j_d         = j_q;
    tr_d        = tr_q;
    tc_d        = tc_q;
    res_found_d = res_found_q;
    res_len_d   = res_len_q;
    res_move_d  = res_move_q;
    res_vmove_d = res_vmove_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cell_we     = 1'b0;
    cell_waddr  = {row_i, col_i};
    cell_wdata  = cell_kind_i;
    cell_raddr  = '0;
    vd_we       = 1'b0;
    vd_waddr    = '0;
    vd_wdata    = '0;
    vd_raddr    = '0;
    q_we        = 1'b0;
    q_waddr     = tail_q[CB-1:0];
    q_wdata     = '0;
    q_raddr     = head_q[CB-1:0];
    path_we     = 1'b0;
    path_waddr  = want;
    path_wdata  = '0;
    path_raddr  = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_i)
            gmb_pkg::FuncLoad: begin
              cell_we = 1'b1;
              if (cell_kind_i == gmb_pkg::KindStart) start_d = {row_i, col_i};
              else if (cell_kind_i == gmb_pkg::KindTarget) target_d = {row_i, col_i};
            end
            gmb_pkg::FuncSolve: begin
              ptr_d   = '0;
              total_d = '0;
              clr_d   = '0;
              state_d = S_CLR;
            end
            gmb_pkg::FuncFetch: begin
              res_found_d = 1'b0;
              res_len_d   = '0;
              res_move_d  = gmb_pkg::MoveUp;
              res_vmove_d = 1'b0;
              res_last_d  = 1'b0;
              if (ptr_q < total_q) state_d = S_FETCH;
              else state_d = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        vd_we    = 1'b1;
        vd_waddr = clr_q;
        clr_d    = clr_q + CB'(1);
        if (clr_q == '1) state_d = S_INIT;
      end
      S_INIT: begin
        if ({1'b0, start_q[CB-1:KB]} < nr_eff && {1'b0, start_q[KB-1:0]} < nc_eff) begin
          vd_we    = 1'b1;
          vd_waddr = start_q;
          vd_wdata = {1'b1, LB'(0)};
          q_we     = 1'b1;
          q_waddr  = '0;
          q_wdata  = start_q;
          head_d   = '0;
          tail_d   = (CB+1)'(1);
          state_d  = S_POP;
        end else begin
          state_d = S_TGT;
        end
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_TGT;
        end else begin
          head_d  = head_q + (CB+1)'(1);
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        cur_d    = q_rdata;
        vd_raddr = q_rdata;
        state_d  = S_DIST;
      end
      S_DIST: begin
        dcur_d  = vd_rdata[LB-1:0];
        k_d     = '0;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        logic          ok;
        logic [CB-1:0] nb;
        ok = 1'b0;
        nb = cur_q;
        // probe order: down, up, right, left
        unique case (k_q)
          2'd0: begin ok = ({1'b0, cr} + NB'(1)) < nr_eff; nb = {cr + RB'(1), cc}; end
          2'd1: begin ok = (cr != '0);                      nb = {cr - RB'(1), cc}; end
          2'd2: begin ok = ({1'b0, cc} + NB'(1)) < nc_eff; nb = {cr, cc + KB'(1)}; end
          default: begin ok = (cc != '0);                   nb = {cr, cc - KB'(1)}; end
        endcase
        if (ok) begin
          cell_raddr = nb;
          vd_raddr   = nb;
          nb_d       = nb;
          state_d    = S_CHECK;
        end else if (k_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_CHECK: begin
        if (cell_rdata == gmb_pkg::KindWall || vd_rdata[LB]) begin
          if (k_q == 2'd3) state_d = S_POP;
          else begin
            k_d     = k_q + 2'd1;
            state_d = S_PROBE;
          end
        end else begin
          vd_we    = 1'b1;
          vd_waddr = nb_q;
          vd_wdata = {1'b1, dcur_q + LB'(1)};
          if (cell_rdata == gmb_pkg::KindTarget) begin
            // target is marked but never expanded
            state_d = S_POP;
          end else begin
            if (!tail_q[CB]) begin
              q_we    = 1'b1;
              q_wdata = nb_q;
              tail_d  = tail_q + (CB+1)'(1);
            end
            if (k_q == 2'd3) state_d = S_POP;
            else begin
              k_d     = k_q + 2'd1;
              state_d = S_PROBE;
            end
          end
        end
      end
      S_TGT: begin
        res_vmove_d = 1'b0;
        res_last_d  = 1'b0;
        res_move_d  = gmb_pkg::MoveUp;
        if ({1'b0, target_q[CB-1:KB]} < nr_eff && {1'b0, target_q[KB-1:0]} < nc_eff) begin
          vd_raddr = target_q;
          state_d  = S_TGT2;
        end else begin
          res_found_d = 1'b0;
          res_len_d   = '0;
          state_d     = S_EMIT;
        end
      end
      S_TGT2: begin
        if (vd_rdata[LB]) begin
          res_found_d = 1'b1;
          res_len_d   = vd_rdata[LB-1:0];
          total_d     = vd_rdata[LB-1:0];
          dist_d      = vd_rdata[LB-1:0];
          tr_d        = target_q[CB-1:KB];
          tc_d        = target_q[KB-1:0];
          j_d         = '0;
          if (vd_rdata[LB-1:0] == '0) state_d = S_EMIT;
          else state_d = S_TPROBE;
        end else begin
          res_found_d = 1'b0;
          res_len_d   = '0;
          state_d     = S_EMIT;
        end
      end
      S_TPROBE: begin
        logic          ok;
        logic [CB-1:0] nb;
        ok = 1'b0;
        nb = {trr, tcc};
        // trace order: up, down, left, then fall back to right
        unique case (j_q)
          2'd0: begin ok = (trr != '0);                       nb = {trr - RB'(1), tcc}; end
          2'd1: begin ok = ({1'b0, trr} + NB'(1)) < nr_eff;   nb = {trr + RB'(1), tcc}; end
          2'd2: begin ok = (tcc != '0);                       nb = {trr, tcc - KB'(1)}; end
          default: begin ok = 1'b0;                           nb = {trr, tcc}; end
        endcase
        if (j_q == 2'd3) begin
          path_we    = 1'b1;
          path_wdata = gmb_pkg::MoveLeft;
          if (({1'b0, tcc} + NB'(1)) < nc_eff) tc_d = tcc + KB'(1);
          dist_d = want;
          j_d    = '0;
          if (want == '0) state_d = S_EMIT;
        end else if (ok) begin
          vd_raddr = nb;
          state_d  = S_TCHK;
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      S_TCHK: begin
        if (vd_rdata[LB] && vd_rdata[LB-1:0] == want) begin
          path_we = 1'b1;
          unique case (j_q)
            2'd0: begin tr_d = trr - RB'(1); path_wdata = gmb_pkg::MoveDown; end
            2'd1: begin tr_d = trr + RB'(1); path_wdata = gmb_pkg::MoveUp; end
            default: begin tc_d = tcc - KB'(1); path_wdata = gmb_pkg::MoveRight; end
          endcase
          dist_d = want;
          j_d    = '0;
          if (want == '0) state_d = S_EMIT;
          else state_d = S_TPROBE;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_TPROBE;
        end
      end
      S_FETCH: begin
        res_move_d  = path_rdata;
        res_vmove_d = 1'b1;
        res_last_d  = (ptr_q + LB'(1)) == total_q;
        ptr_d       = ptr_q + LB'(1);
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_count_q <= gmb_pkg::RowLimit;
      col_count_q <= gmb_pkg::ColLimit;
      start_q     <= '0;
      target_q    <= '0;
      ptr_q       <= '0;
      total_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      target_q    <= target_d;
      ptr_q       <= ptr_d;
      total_q     <= total_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gmb_pkg::RegRowCount: row_count_q <= cfg_wdata_i;
          gmb_pkg::RegColCount: col_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    nb_q        <= nb_d;
    clr_q       <= clr_d;
    dcur_q      <= dcur_d;
    dist_q      <= dist_d;
    k_q         <= k_d;
    j_q         <= j_d;
    tr_q        <= tr_d;
    tc_q        <= tc_d;
    res_found_q <= res_found_d;
    res_len_q   <= res_len_d;
    res_move_q  <= res_move_d;
    res_vmove_q <= res_vmove_d;
    res_last_q  <= res_last_d;
    if (state_q == S_EMIT && out_load) begin
      found_q <= res_found_q;
      len_q   <= res_len_q;
      move_q  <= res_move_q;
      vmove_q <= res_vmove_q;
      last_q  <= res_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign path_length_o = len_q;
  assign move_o        = move_q;
  assign valid_move_o  = vmove_q;
  assign last_move_o   = last_q;

  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_EMIT)
    else $error("result offered outside emit");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("frontier head passed tail");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= total_q)
    else $error("move pointer beyond path");

  a_move_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_move_o |-> !found_o && path_length_o == '0)
    else $error("move result carries solve fields");

endmodule

`default_nettype wire

### hdl/gmb_ram.sv
// ----------------------------------------------------------------------------
// gmb_ram
// simple dual-port ram: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module gmb_ram #(
  parameter int unsigned Width    = 2,
  parameter int unsigned AddrBits = 12
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [1 << AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
